// ===== hdl/htfc_pkg.sv =====
// ----------------------------------------------------------------------------
// htfc_pkg
// Shared types and constants for the hysteresis thermostat fan controller.
// ----------------------------------------------------------------------------
package htfc_pkg;

  localparam int TEMP_W   = 9;
  localparam int SET_W    = 8;
  localparam int LEVEL_W  = 8;
  localparam int PROD_W   = 16;
  localparam int CNT_W    = 4;
  localparam int ADDR_W   = 5;
  localparam int DATA_W   = 32;

  localparam logic [LEVEL_W-1:0] HYST_RST     = 8'd2;
  localparam logic [LEVEL_W-1:0] BIG_DIFF_RST = 8'd10;
  localparam logic [LEVEL_W-1:0] FAN_OFF_RST  = 8'd0;
  localparam logic [LEVEL_W-1:0] FAN_MID_RST  = 8'd128;
  localparam logic [LEVEL_W-1:0] FAN_ON_RST   = 8'd255;

  typedef enum logic [2:0] {
    REG_HYSTERESIS = 3'd0,
    REG_BIG_DIFF   = 3'd1,
    REG_FAN_OFF    = 3'd2,
    REG_FAN_MID    = 3'd3,
    REG_FAN_ON     = 3'd4
  } reg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE = 3'd0,
    S_EVAL = 3'd1,
    S_MUL  = 3'd2,
    S_DIV  = 3'd3,
    S_DONE = 3'd4
  } state_t;

endpackage

// ===== hdl/hysteresis_thermostat_fan_control_top.sv =====
// ----------------------------------------------------------------------------
// hysteresis_thermostat_fan_control_top
// Bang-bang thermostat with hysteresis and a linear cooling fan ramp.
// ----------------------------------------------------------------------------
// One transfer in gives one transfer out. An item is decided in the cycle after
// it is taken; when the fan ramp applies, an 8x8 multiply and a restoring
// shift-subtract divider follow before the result is ready. The input
// is ready again once the result sits in the output register, which may wait
// for the sink while the next item is taken. Registers are written over APB
// at byte address 4*i; the user must write them only while the block is
// idle, as the block itself does not enforce it.
// ----------------------------------------------------------------------------
module hysteresis_thermostat_fan_control_top
  import htfc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [23:0]       in_tdata,   // inside_temp[8:0], target_temp[16:9]
  input  logic [0:0]        in_tuser,   // restart
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [15:0]       out_tdata,  // heater_on[0], fan_duty[8:1], heating_now[9]
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [ADDR_W-1:0] cfg_paddr,
  input  logic [DATA_W-1:0] cfg_pwdata,
  output logic [DATA_W-1:0] cfg_prdata,
  output logic              cfg_pready
);

  state_t state_r, state_nxt;

  logic [LEVEL_W-1:0] hyst_r, big_diff_r, fan_off_r, fan_mid_r, fan_on_r;

  logic signed [TEMP_W-1:0] temp_r;
  logic [SET_W-1:0]         set_r;
  logic                     restart_r;

  logic               heating_mode_r, latched_r, heater_r;
  logic [LEVEL_W-1:0] fan_r;

  logic [LEVEL_W-1:0] delta_r, mag_r, rem_r;
  logic               neg_r;
  logic [PROD_W-1:0]  quo_r;
  logic [CNT_W-1:0]   cnt_r;

  logic               out_valid_r;
  logic               out_heater_r, out_heating_r;
  logic [LEVEL_W-1:0] out_fan_r;

  // APB
  logic     cfg_wr;
  reg_idx_t cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[4:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hyst_r     <= HYST_RST;
      big_diff_r <= BIG_DIFF_RST;
      fan_off_r  <= FAN_OFF_RST;
      fan_mid_r  <= FAN_MID_RST;
      fan_on_r   <= FAN_ON_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_HYSTERESIS: hyst_r     <= cfg_pwdata[LEVEL_W-1:0];
        REG_BIG_DIFF:   big_diff_r <= cfg_pwdata[LEVEL_W-1:0];
        REG_FAN_OFF:    fan_off_r  <= cfg_pwdata[LEVEL_W-1:0];
        REG_FAN_MID:    fan_mid_r  <= cfg_pwdata[LEVEL_W-1:0];
        REG_FAN_ON:     fan_on_r   <= cfg_pwdata[LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_HYSTERESIS: cfg_prdata = {{(DATA_W-LEVEL_W){1'b0}}, hyst_r};
      REG_BIG_DIFF:   cfg_prdata = {{(DATA_W-LEVEL_W){1'b0}}, big_diff_r};
      REG_FAN_OFF:    cfg_prdata = {{(DATA_W-LEVEL_W){1'b0}}, fan_off_r};
      REG_FAN_MID:    cfg_prdata = {{(DATA_W-LEVEL_W){1'b0}}, fan_mid_r};
      REG_FAN_ON:     cfg_prdata = {{(DATA_W-LEVEL_W){1'b0}}, fan_on_r};
      default:        cfg_prdata = '0;
    endcase
  end

  // Decision logic, 11-bit signed compares
  logic signed [10:0] t_x, s_x, h_x, b_x, dts;
  logic               t_gt_s, t_lo_h, t_hi_b, t_gt_sh, t_lo_b;
  logic               mode_eff, latch_eff;
  logic               mode_new, latch_new, heater_new, ramp_new;
  logic [LEVEL_W-1:0] fan_new;
  logic signed [8:0]  lvl_diff;
  logic               in_xfer, out_load, div_last;
  logic [8:0]         rem_sh;
  logic               rem_ge;

  assign t_x     = {{2{temp_r[TEMP_W-1]}}, temp_r};
  assign s_x     = {3'b000, set_r};
  assign h_x     = {3'b000, hyst_r};
  assign b_x     = {3'b000, big_diff_r};
  assign dts     = t_x - s_x;
  assign t_gt_s  = t_x > s_x;
  assign t_lo_h  = (t_x + h_x) < s_x;
  assign t_hi_b  = (t_x - b_x) > s_x;
  assign t_gt_sh = t_x > (s_x + h_x);
  assign t_lo_b  = (t_x + b_x) < s_x;

  assign mode_eff  = restart_r ? ~t_gt_s : heating_mode_r;
  assign latch_eff = restart_r ? 1'b0 : latched_r;
  assign lvl_diff  = $signed({1'b0, fan_on_r}) - $signed({1'b0, fan_off_r});

  always_comb begin
    mode_new   = mode_eff;
    latch_new  = latch_eff;
    heater_new = heater_r;
    fan_new    = fan_r;
    ramp_new   = 1'b0;
    if (mode_eff) begin
      if (t_lo_h) begin
        heater_new = 1'b1;
        fan_new    = fan_off_r;
      end else if (t_hi_b) begin
        mode_new   = 1'b0;
        heater_new = 1'b0;
        fan_new    = fan_mid_r;
      end else if (t_gt_s) begin
        heater_new = 1'b0;
        fan_new    = fan_off_r;
      end
    end else begin
      if (t_gt_s) begin
        heater_new = 1'b0;
        latch_new  = latch_eff | t_gt_sh;
        if (latch_eff | t_gt_sh) begin
          if (t_hi_b) fan_new = fan_on_r;
          else        ramp_new = 1'b1;
        end else begin
          fan_new = fan_off_r;
        end
      end else if (t_lo_b) begin
        mode_new   = 1'b1;
        latch_new  = 1'b0;
        heater_new = 1'b1;
        fan_new    = fan_off_r;
      end else begin
        latch_new  = 1'b0;
        heater_new = 1'b0;
        fan_new    = fan_off_r;
      end
    end
  end

  assign in_tready = (state_r == S_IDLE);
  assign in_xfer   = in_tvalid & in_tready;
  assign out_load  = (state_r == S_DONE) & (~out_valid_r | out_tready);
  assign div_last  = (cnt_r == {CNT_W{1'b1}});
  assign rem_sh    = {rem_r, quo_r[PROD_W-1]};
  assign rem_ge    = rem_sh >= {1'b0, big_diff_r};

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_xfer) state_nxt = S_EVAL;
      S_EVAL: state_nxt = ramp_new ? S_MUL : S_DONE;
      S_MUL:  state_nxt = S_DIV;
      S_DIV:  if (div_last) state_nxt = S_DONE;
      S_DONE: if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      heating_mode_r <= 1'b0;
      latched_r      <= 1'b0;
      heater_r       <= 1'b0;
      fan_r          <= '0;
      cnt_r          <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      case (state_r)
        S_EVAL: begin
          heating_mode_r <= mode_new;
          latched_r      <= latch_new;
          heater_r       <= heater_new;
          if (!ramp_new) fan_r <= fan_new;
          cnt_r          <= '0;
        end
        S_DIV: begin
          cnt_r <= cnt_r + 1'b1;
          if (div_last) begin
            if (neg_r) fan_r <= fan_off_r - {quo_r[LEVEL_W-2:0], rem_ge};
            else       fan_r <= fan_off_r + {quo_r[LEVEL_W-2:0], rem_ge};
          end
        end
        default: ;
      endcase
      if (out_load)                      out_valid_r <= 1'b1;
      else if (out_valid_r & out_tready) out_valid_r <= 1'b0;
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      temp_r    <= in_tdata[8:0];
      set_r     <= in_tdata[16:9];
      restart_r <= in_tuser[0];
    end
    case (state_r)
      S_EVAL: begin
        delta_r <= dts[LEVEL_W-1:0];
        neg_r   <= lvl_diff[8];
        mag_r   <= lvl_diff[8] ? LEVEL_W'(-lvl_diff) : lvl_diff[LEVEL_W-1:0];
      end
      S_MUL: begin
        quo_r <= delta_r * mag_r;
        rem_r <= '0;
      end
      S_DIV: begin
        quo_r <= {quo_r[PROD_W-2:0], rem_ge};
        rem_r <= rem_ge ? LEVEL_W'(rem_sh - {1'b0, big_diff_r}) : rem_sh[LEVEL_W-1:0];
      end
      default: ;
    endcase
    if (out_load) begin
      out_heater_r  <= heater_r;
      out_fan_r     <= fan_r;
      out_heating_r <= heating_mode_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b0, out_heating_r, out_fan_r, out_heater_r};

  a_accept_eval: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> state_r == S_EVAL) else $error("accepted item not evaluated");

  a_div_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) && div_last |=> state_r == S_DONE)
    else $error("divider did not finish");

  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(state_r == S_DONE))
    else $error("result without completed item");

  a_heater_mode: assert property (@(posedge clk) disable iff (!rst_n)
    heater_r |-> heating_mode_r) else $error("heater on in cooling mode");

endmodule
